>>> design/assert_macros.svh
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies a consequence on the same edge
`define ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// Check that a condition implies a consequence on the next edge
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

>>> design/wbce_pkg.sv
// ----------------------------------------------------------------------------
// wbce_pkg
// Shared constants and types of the weighted cross-entropy loss block.
// ----------------------------------------------------------------------------
package wbce_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ACC_WIDTH_DEF = 48;
  localparam int OUT_W = 40;
  localparam int LG_BITS = 30;
  localparam logic [27:0] LN2_Q28 = 28'd186065279;

  typedef enum logic [1:0] {
    REG_BETA_ENABLE = 2'd0,
    REG_BETA_VALUE  = 2'd1,
    REG_BATCH_COUNT = 2'd2,
    REG_LOG_FLOOR   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_LOG, BK_MUL, BK_TERM, BK_ACC, BK_DIV, BK_OUT
  } bk_state_t;
endpackage

>>> design/wbce_front.sv
// ----------------------------------------------------------------------------
// wbce_front
// Accepts items, forms the clamped probability and the weight.
// ----------------------------------------------------------------------------
module wbce_front import wbce_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FRAC_BITS:0]   x_in,
  input  logic [FRAC_BITS:0]   t_in,
  input  logic                 last_in,
  input  logic                 beta_enable,
  input  logic [FRAC_BITS:0]   beta_value,
  input  logic [FRAC_BITS:0]   log_floor,
  output logic                 q_valid,
  input  logic                 q_stall,
  output logic [FRAC_BITS:0]   q_prob,
  output logic [FRAC_BITS:0]   q_w,
  output logic                 q_last
);
  localparam int W = FRAC_BITS + 1;
  localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;
  localparam int PW = 2 * FRAC_BITS + 2;

  logic [W-1:0] x, t, b, fl;
  logic [PW-1:0] psum, wsum;
  logic [W-1:0] prob, w;

  always_comb begin
    x  = (x_in > ONE) ? ONE : x_in;
    t  = (t_in > ONE) ? ONE : t_in;
    b  = (beta_value > ONE) ? ONE : beta_value;
    fl = (log_floor > ONE) ? ONE : log_floor;
    if (fl == '0) fl = W'(1);
    psum = PW'(t) * PW'(x) + PW'(ONE - t) * PW'(ONE - x) + PW'(ONE >> 1);
    prob = W'(psum >> FRAC_BITS);
    if (prob < fl) prob = fl;
    wsum = PW'(t) * PW'(ONE - b) + PW'(ONE - t) * PW'(b) + PW'(ONE >> 1);
    w = beta_enable ? W'(wsum >> FRAC_BITS) : ONE;
  end

  // two-entry queue toward the back part
  logic [2*W:0] mem [2];
  logic         wp, rp;
  logic [1:0]   cnt;
  logic         push, pop;

  assign in_stall = (cnt == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt != 2'd0);
  assign pop = q_valid && !q_stall;
  assign {q_prob, q_w, q_last} = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= {prob, w, last_in};
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule

>>> design/wbce_back.sv
// ----------------------------------------------------------------------------
// wbce_back
// Iterative log, weighting, saturating accumulate and serial divide.
// ----------------------------------------------------------------------------
module wbce_back import wbce_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_stall,
  input  logic [FRAC_BITS:0]   q_prob,
  input  logic [FRAC_BITS:0]   q_w,
  input  logic                 q_last,
  input  logic [15:0]          batch_count,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_W-1:0]     mean_loss,
  output logic                 saturated
);
  localparam int W = FRAC_BITS + 1;
  localparam int MW = LG_BITS + 2;
  localparam int SH = LG_BITS + 28 - FRAC_BITS;
  localparam int NW = LG_BITS + 6;
  localparam int PW = NW + 28;
  localparam int TW = PW - SH + W;
  localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;
  localparam int CW = $clog2(ACC_WIDTH + 1);
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  bk_state_t state, state_next;
  logic [MW-1:0] m;
  logic [LG_BITS-1:0] frac;
  logic [CW-1:0] cnt;
  logic [5:0] msb;
  logic [W-1:0] w;
  logic last;
  logic [PW-1:0] prod;
  logic [TW-1:0] term;
  logic [ACC_WIDTH-1:0] acc, quo, rem;
  logic clip;

  logic [5:0] msb_c;
  logic [2*MW-1:0] sq;
  logic [MW-1:0] m_sq;
  logic [ACC_WIDTH:0] rem_sh;
  logic [ACC_WIDTH:0] sum_c;
  logic [15:0] div;
  logic [NW-1:0] nlog2;

  always_comb begin
    msb_c = '0;
    for (int i = 0; i <= FRAC_BITS; i++) if (q_prob[i]) msb_c = 6'(i);
    sq = 64'(m) * 64'(m);
    m_sq = MW'(sq >> LG_BITS);
    div = (batch_count == '0) ? 16'd1 : batch_count;
    rem_sh = {rem, quo[ACC_WIDTH-1]};
    nlog2 = (NW'(FRAC_BITS - int'(msb)) << LG_BITS) - NW'(frac);
    sum_c = {1'b0, acc} + (ACC_WIDTH+1)'(term);
  end

  assign q_stall = (state != BK_IDLE);
  assign out_valid = (state == BK_OUT);

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (q_valid) state_next = BK_LOG;
      BK_LOG:  if (cnt == CW'(LG_BITS - 1)) state_next = BK_MUL;
      BK_MUL:  state_next = BK_TERM;
      BK_TERM: state_next = BK_ACC;
      BK_ACC:  state_next = last ? BK_DIV : BK_IDLE;
      BK_DIV:  if (cnt == CW'(ACC_WIDTH - 1)) state_next = BK_OUT;
      BK_OUT:  if (!out_stall) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      clip <= 1'b0;
    end else begin
      case (state)
        BK_IDLE: begin
          m <= MW'(q_prob) << (LG_BITS - int'(msb_c));
          msb <= msb_c;
          w <= q_w;
          last <= q_last;
          frac <= '0;
          cnt <= '0;
        end
        BK_LOG: begin
          // one log2 bit per square
          if (m_sq >= (MW'(2) << LG_BITS)) begin
            m <= m_sq >> 1;
            frac <= {frac[LG_BITS-2:0], 1'b1};
          end else begin
            m <= m_sq;
            frac <= {frac[LG_BITS-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
        end
        BK_MUL: prod <= PW'(nlog2) * PW'(LN2_Q28) + (PW'(1) << (SH - 1));
        BK_TERM: term <= TW'(((TW'(prod >> SH) * TW'(w)) + TW'(1 << (FRAC_BITS - 1)))
                              >> FRAC_BITS);
        BK_ACC: begin
          if (sum_c > (ACC_WIDTH+1)'(ACC_MAX)) begin
            acc <= ACC_MAX;
            clip <= 1'b1;
          end else acc <= sum_c[ACC_WIDTH-1:0];
          quo <= (sum_c > (ACC_WIDTH+1)'(ACC_MAX)) ? ACC_MAX : sum_c[ACC_WIDTH-1:0];
          rem <= '0;
          cnt <= '0;
        end
        BK_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (rem_sh >= (ACC_WIDTH+1)'(div)) begin
            rem <= ACC_WIDTH'(rem_sh - (ACC_WIDTH+1)'(div));
            quo <= {quo[ACC_WIDTH-2:0], 1'b1};
          end else begin
            rem <= rem_sh[ACC_WIDTH-1:0];
            quo <= {quo[ACC_WIDTH-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
        end
        BK_OUT: if (!out_stall) begin
          acc <= '0;
          clip <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ACC_WIDTH > OUT_W && (quo >> OUT_W) != '0) begin
      mean_loss = OUT_MAX;
      saturated = 1'b1;
    end else begin
      mean_loss = OUT_W'(quo);
      saturated = clip;
    end
  end
endmodule

>>> design/weighted_binary_cross_entropy_loss.sv
// ----------------------------------------------------------------------------
// weighted_binary_cross_entropy_loss
// Class-balanced binary cross-entropy, summed per batch and averaged.
// ----------------------------------------------------------------------------
// channel | signals                          | accepted when
// in      | in_valid prediction target last  | in_valid && !in_stall
// out     | out_valid mean_loss saturated    | out_valid && !out_stall
// cfg     | cfg_we cfg_index cfg_data        | cfg_we
// Back part: log (one log bit per squaring), multiply, term, accumulate;
// a last item adds a serial divide and an output state. A two-entry queue
// lets the front accept while the back works. Reset is synchronous; the
// result holds while out_stall is high.
module weighted_binary_cross_entropy_loss import wbce_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FRAC_BITS:0]   prediction,
  input  logic [FRAC_BITS:0]   target,
  input  logic                 last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_W-1:0]     mean_loss,
  output logic                 saturated,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [16:0]          cfg_data
);
  logic beta_enable;
  logic [FRAC_BITS:0] beta_value, log_floor;
  logic [15:0] batch_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      beta_enable <= 1'b0;
      beta_value <= (FRAC_BITS+1)'(1) << (FRAC_BITS - 1);
      batch_count <= 16'd1;
      log_floor <= (FRAC_BITS+1)'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BETA_ENABLE: beta_enable <= cfg_data[0];
        REG_BETA_VALUE:  beta_value <= (FRAC_BITS+1)'(cfg_data);
        REG_BATCH_COUNT: batch_count <= cfg_data[15:0];
        REG_LOG_FLOOR:   log_floor <= (FRAC_BITS+1)'(cfg_data);
        default: ;
      endcase
    end
  end

  logic q_valid, q_stall, q_last;
  logic [FRAC_BITS:0] q_prob, q_w;

  wbce_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .in_valid, .in_stall, .x_in(prediction), .t_in(target),
    .last_in(last), .beta_enable, .beta_value, .log_floor,
    .q_valid, .q_stall, .q_prob, .q_w, .q_last
  );

  wbce_back #(.FRAC_BITS(FRAC_BITS), .ACC_WIDTH(ACC_WIDTH)) u_back (
    .clk, .rst, .q_valid, .q_stall, .q_prob, .q_w, .q_last, .batch_count,
    .out_valid, .out_stall, .mean_loss, .saturated
  );
endmodule

>>> design/wbce_checker.sv
// ----------------------------------------------------------------------------
// wbce_checker
// Port-level checks of the loss block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module wbce_checker import wbce_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [OUT_W-1:0] mean_loss,
  input logic             saturated
);
  `ASSERT_NEXT(out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(mean_loss))
  `ASSERT_IMPL(max_flags, clk, rst, out_valid && !saturated, mean_loss != '1)
  `ASSERT_NEXT(out_one, clk, rst, out_valid && !out_stall, !out_valid)
  `ASSERT_NEXT(rst_open, clk, 1'b0, rst, !in_stall && !out_valid)
endmodule

bind weighted_binary_cross_entropy_loss wbce_checker u_chk (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .mean_loss, .saturated
);

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Weighted binary cross-entropy loss testbench
// Drives (prediction, target, last) items through the loss block, predicts
// each batch mean with an independent fixed-point model, and compares every
// result in order. Runs several register settings and idling phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import wbce_pkg::*;

  localparam int FB = 16;
  localparam int AW = 48;
  localparam longint unsigned ONE = 64'd1 << FB;
  localparam logic [FB:0] ONE_IN = 17'h10000;
  localparam longint unsigned SUM_MAX = (64'd1 << AW) - 1;
  localparam longint unsigned MEAN_MAX = (64'd1 << OUT_W) - 1;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [OUT_W-1:0] mean;
    logic             clip;
  } batch_mean_t;

  class mean_scoreboard;
    longint unsigned bal_en, beta, divisor, floor_q;
    longint unsigned acc;
    bit acc_clip;
    batch_mean_t pending[$];
    int errors;

    function new();
      bal_en = 0; beta = 32768; divisor = 1; floor_q = 1;
      acc = 0; acc_clip = 0; errors = 0;
    endfunction

    function longint unsigned clamp1(longint unsigned v);
      return v > ONE ? ONE : v;
    endfunction

    function void set_reg(reg_idx_t idx, longint unsigned v);
      case (idx)
        REG_BETA_ENABLE: bal_en = v & 1;
        REG_BETA_VALUE:  beta = v & 'h1FFFF;
        REG_BATCH_COUNT: divisor = v & 'hFFFF;
        REG_LOG_FLOOR:   floor_q = v & 'h1FFFF;
        default: ;
      endcase
    endfunction

    // -ln(p) in Q.16 via bit-serial log2 by repeated squaring
    function longint unsigned minus_ln(longint unsigned p);
      int top;
      longint unsigned m, fr, l2;
      top = 0; fr = 0;
      if (p == 0) p = 1;
      for (int i = 0; i <= FB; i++) if (p[i]) top = i;
      m = p << (LG_BITS - top);
      for (int i = 0; i < LG_BITS; i++) begin
        m = (m * m) >> LG_BITS;
        fr = fr << 1;
        if (m >= (64'd2 << LG_BITS)) begin
          fr |= 1;
          m = m >> 1;
        end
      end
      l2 = (longint'(FB - top) << LG_BITS) - fr;
      return (l2 * LN2_Q28 + (64'd1 << (LG_BITS + 28 - FB - 1))) >> (LG_BITS + 28 - FB);
    endfunction

    function void note_item(logic [FB:0] pred, logic [FB:0] tgt, logic lst);
      longint unsigned x, t, fl, pr, w, term, q, b;
      batch_mean_t e;
      x = clamp1(pred); t = clamp1(tgt);
      fl = clamp1(floor_q);
      if (fl == 0) fl = 1;
      pr = (t * x + (ONE - t) * (ONE - x) + ONE / 2) >> FB;
      if (pr < fl) pr = fl;
      if (bal_en != 0) begin
        b = clamp1(beta);
        w = (t * (ONE - b) + (ONE - t) * b + ONE / 2) >> FB;
      end else w = ONE;
      term = (minus_ln(pr) * w + ONE / 2) >> FB;
      if (acc > SUM_MAX - term) begin
        acc = SUM_MAX;
        acc_clip = 1;
      end else acc += term;
      if (lst) begin
        q = acc / (divisor == 0 ? 1 : divisor);
        e.clip = acc_clip;
        if (q > MEAN_MAX) begin
          q = MEAN_MAX;
          e.clip = 1;
        end
        e.mean = q[OUT_W-1:0];
        pending.push_back(e);
        acc = 0; acc_clip = 0;
      end
    endfunction

    function void check_mean(logic [OUT_W-1:0] m, logic c);
      batch_mean_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result mean=%0d sat=%0b", m, c);
        return;
      end
      e = pending.pop_front();
      if (e.mean !== m || e.clip !== c) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected mean=%0d sat=%0b, got mean=%0d sat=%0b",
                   e.mean, e.clip, m, c);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall;
  logic [FB:0] prediction = '0, target = '0;
  logic last = 0;
  logic out_valid, out_stall = 0;
  logic [OUT_W-1:0] mean_loss;
  logic saturated;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;

  int idle_pct = 0, stall_pct = 0;
  int quiet_cycles = 0;
  mean_scoreboard sb;

  weighted_binary_cross_entropy_loss DUT (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_item(prediction, target, last);
      if (out_valid && !out_stall) sb.check_mean(mean_loss, saturated);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // leave valid high on return; the next send or drain drives it again
  task automatic send_item(logic [FB:0] p, logic [FB:0] t, logic l);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; prediction <= p; target <= t; last <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // drain outstanding results, then let the back end finish its last item
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [16:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, v);
    @(negedge clk);
  endtask

  function automatic logic [FB:0] rand_q();
    case ($urandom_range(5))
      0: return '0;
      1: return ONE_IN;
      2: return 17'($urandom_range(131071));
      3: return 17'($urandom_range(40));
      4: return ONE_IN - 17'($urandom_range(40));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  task automatic random_batches(int n_items, int max_len);
    int k;
    k = 0;
    while (k < n_items) begin
      int len;
      len = $urandom_range(max_len, 1);
      for (int j = 0; j < len; j++) begin
        send_item(rand_q(), ($urandom_range(1) ? rand_q() : ($urandom_range(1) ? ONE_IN : '0)),
                  j == len - 1);
        k++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: field extremes, soft labels, above-one values, floor
    send_item(0, 0, 1);
    send_item(ONE_IN, ONE_IN, 1);
    send_item(0, ONE_IN, 1);
    send_item(ONE_IN, 0, 1);
    send_item(17'h1FFFF, 17'h1FFFF, 1);
    send_item(17'h1FFFF, 0, 0);
    send_item(32768, 32768, 0);
    send_item(1, 65535, 1);
    send_item(17'h15555, 17'h0AAAA, 1);
    drain();
    write_reg(REG_BETA_ENABLE, 1);
    write_reg(REG_BETA_VALUE, 17'h1FFFF);
    write_reg(REG_LOG_FLOOR, 0);
    write_reg(REG_BATCH_COUNT, 0);
    send_item(0, ONE_IN, 1);
    send_item(ONE_IN, 0, 1);
    send_item(12345, 40000, 1);
    drain();
    write_reg(REG_BETA_VALUE, 0);
    write_reg(REG_LOG_FLOOR, 17'h1FFFF);
    write_reg(REG_BATCH_COUNT, 17'h0FFFF);
    send_item(0, ONE_IN, 0);
    send_item(5000, 60000, 1);
    send_item(0, 0, 1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 12 : 56) : 0;
      stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 12 : 56) : 0;
      write_reg(REG_BETA_ENABLE, 17'($urandom_range(1)));
      write_reg(REG_BETA_VALUE, ph == 0 ? ONE_IN : 17'($urandom_range(65536)));
      write_reg(REG_BATCH_COUNT, ph == 1 ? 17'd1 : 17'($urandom_range(65535, 1)));
      write_reg(REG_LOG_FLOOR, ph == 2 ? ONE_IN : 17'($urandom_range(2000, 1)));
      random_batches(150, 12);
      drain();
    end
    idle_pct = 0; stall_pct = 0;
    write_reg(REG_LOG_FLOOR, 1);
    write_reg(REG_BETA_ENABLE, 0);
    write_reg(REG_BATCH_COUNT, 1);
    random_batches(40, 3);
    drain();

    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

>>> weighted_binary_cross_entropy_loss.f
+incdir+design
design/wbce_pkg.sv
design/wbce_front.sv
design/wbce_back.sv
design/weighted_binary_cross_entropy_loss.sv
design/wbce_checker.sv
sim/testbench.sv
